@@ rtl/shc_pkg.sv @@
package shc_pkg;

  localparam int MaxHits = 64;
  localparam int IdxW = $clog2(MaxHits);
  localparam int CntW = $clog2(MaxHits + 1);
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);

  typedef struct packed {
    logic [5:0] chamber_id;
    logic [3:0] eta_sector;
    logic [9:0] strip_num;
    logic       end_of_event;
  } hit_in_t;

  typedef struct packed {
    logic [5:0]  out_chamber;
    logic [3:0]  out_eta;
    logic [9:0]  first_strip;
    logic [9:0]  last_strip;
    logic [10:0] cluster_size;
    logic        overflow;
    logic        final_cluster;
  } cluster_out_t;

  // One hit as it travels from the front part to the back part.
  typedef struct packed {
    logic [5:0] chamber;
    logic [3:0] eta;
    logic [9:0] strip;
    logic       last;
    logic       dropped;
  } hit_entry_t;

  typedef enum logic [2:0] {
    StLoad,
    StSeek,
    StSeed,
    StScan,
    StEmit
  } clus_state_e;

endpackage

@@ rtl/shc_front.sv @@
// Accepts hits, counts them against the store capacity and hands
// stored or event-closing hits to the queue with a drop marker.
module shc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  shc_pkg::hit_in_t        in_data_i,
  output logic                    q_valid_o,
  input  logic                    q_full_i,
  output shc_pkg::hit_entry_t     q_data_o
);

  logic [shc_pkg::CntW-1:0] count_q, count_d;
  logic                     drop_q, drop_d;
  logic                     full_store;
  logic                     accept;

  assign full_store = (count_q == shc_pkg::CntW'(shc_pkg::MaxHits));
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // A hit goes to the queue if it is stored or if it closes the event.
  assign q_valid_o         = accept && (!full_store || in_data_i.end_of_event);
  assign q_data_o.chamber  = in_data_i.chamber_id;
  assign q_data_o.eta      = in_data_i.eta_sector;
  assign q_data_o.strip    = in_data_i.strip_num;
  assign q_data_o.last     = in_data_i.end_of_event;
  assign q_data_o.dropped  = full_store;

  // Count and drop flag for the event in progress.
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (accept) begin
      if (in_data_i.end_of_event) begin
        count_d = '0;
        drop_d  = 1'b0;
      end else if (full_store) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

endmodule

@@ rtl/shc_queue.sv @@
// Small queue between the front and back parts.
module shc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  shc_pkg::hit_entry_t wr_data_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                rd_i,
  output shc_pkg::hit_entry_t rd_data_o
);

  shc_pkg::hit_entry_t mem_q [shc_pkg::QueueDepth];
  logic [shc_pkg::QPtrW:0] wp_q, rp_q;

  assign empty_o   = (wp_q == rp_q);
  assign full_o    = (wp_q[shc_pkg::QPtrW-1:0] == rp_q[shc_pkg::QPtrW-1:0]) &&
                     (wp_q[shc_pkg::QPtrW] != rp_q[shc_pkg::QPtrW]);
  assign rd_data_o = mem_q[rp_q[shc_pkg::QPtrW-1:0]];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) begin
      mem_q[wp_q[shc_pkg::QPtrW-1:0]] <= wr_data_i;
    end
  end

  // Pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= rp_q + 1'b1;
    end
  end

endmodule

@@ rtl/shc_back.sv @@
// Stores an event's hits, then clusters them by repeated scans of the store.
module shc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  shc_pkg::hit_entry_t  q_data_i,
  output logic                 q_rd_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output shc_pkg::cluster_out_t out_data_o
);

  localparam int IW = shc_pkg::IdxW;
  localparam int CW = shc_pkg::CntW;

  shc_pkg::clus_state_e state_q, state_d;

  logic [19:0]              store_q [shc_pkg::MaxHits];
  logic [shc_pkg::MaxHits-1:0] rem_q;
  logic [CW-1:0]            count_q;
  logic                     drop_q;
  logic [CW-1:0]            seed_q;
  logic [CW-1:0]            j_q;
  logic                     grew_q;
  logic [5:0]               ch_q;
  logic [3:0]               eta_q;
  logic [9:0]               first_q, last_q;
  logic [19:0]              rd_q;
  logic                     ov_q;
  shc_pkg::cluster_out_t    out_q;
  logic                     out_v_q;

  logic [CW-1:0] seek_next;
  logic          more_seed;
  logic          take_hit;
  logic          out_free;
  logic [5:0]    g_ch;
  logic [3:0]    g_eta;
  logic [9:0]    g_strip;
  logic          j_end;
  logic          j_rem;
  logic          absorb_lo, absorb_hi;
  logic          last_clus;

  assign out_free  = !out_v_q || !out_stall_i;
  assign take_hit  = (state_q == shc_pkg::StLoad) && !q_empty_i;
  assign q_rd_o    = take_hit;
  assign g_ch      = rd_q[19:14];
  assign g_eta     = rd_q[13:10];
  assign g_strip   = rd_q[9:0];
  assign j_end     = (j_q >= count_q);
  assign j_rem     = !j_end && rem_q[j_q[IW-1:0]];
  assign absorb_lo = (first_q != '0) && (g_strip == first_q - 1'b1);
  assign absorb_hi = (last_q != '1) && (g_strip == last_q + 1'b1);

  // The cluster being emitted is the last one once no hit remains.
  assign last_clus = ~|rem_q;

  // Finds the next remaining hit from seed onward (one scan step per cycle).
  assign more_seed = (seed_q < count_q) && rem_q[seed_q[IW-1:0]];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shc_pkg::StLoad: begin
        if (take_hit && q_data_i.last) state_d = shc_pkg::StSeek;
      end
      shc_pkg::StSeek: begin
        if (seed_q >= count_q) state_d = shc_pkg::StLoad;
        else if (more_seed) state_d = shc_pkg::StSeed;
      end
      shc_pkg::StSeed: state_d = shc_pkg::StScan;
      shc_pkg::StScan: begin
        if (j_end || (j_rem && (g_ch != ch_q || g_eta != eta_q))) begin
          if (!grew_q) state_d = shc_pkg::StEmit;
        end
      end
      shc_pkg::StEmit: begin
        if (out_free) state_d = last_clus ? shc_pkg::StLoad : shc_pkg::StSeek;
      end
      default: state_d = shc_pkg::StLoad;
    endcase
  end

  // Store write and registered store read for the scan.
  always_ff @(posedge clk_i) begin
    if (take_hit && !q_data_i.dropped) begin
      store_q[count_q[IW-1:0]] <= {q_data_i.chamber, q_data_i.eta, q_data_i.strip};
    end
    rd_q <= store_q[seek_next[IW-1:0]];
  end

  // Address read in the next cycle.
  always_comb begin
    seek_next = seed_q;
    priority if (state_q == shc_pkg::StScan || state_q == shc_pkg::StSeed) begin
      seek_next = (state_q == shc_pkg::StSeed) ? seed_q + 1'b1 : j_q + 1'b1;
      if (state_q == shc_pkg::StScan &&
          (j_end || (j_rem && (g_ch != ch_q || g_eta != eta_q))))
        seek_next = seed_q + 1'b1;
    end else begin
      seek_next = seed_q;
    end
  end

  // Clustering datapath and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shc_pkg::StLoad;
      rem_q   <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
      seed_q  <= '0;
      j_q     <= '0;
      grew_q  <= 1'b0;
      out_v_q <= 1'b0;
      ch_q    <= '0;
      eta_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
      ov_q    <= 1'b0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == shc_pkg::StEmit && out_free) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        shc_pkg::StLoad: begin
          if (take_hit) begin
            if (!q_data_i.dropped) begin
              rem_q[count_q[IW-1:0]] <= 1'b1;
              count_q <= count_q + 1'b1;
            end
            if (q_data_i.dropped) drop_q <= 1'b1;
            if (q_data_i.last) begin
              seed_q <= '0;
              ov_q   <= drop_q || q_data_i.dropped;
            end
          end
        end
        shc_pkg::StSeek: begin
          if (seed_q < count_q && !more_seed) seed_q <= seed_q + 1'b1;
        end
        shc_pkg::StSeed: begin
          ch_q    <= rd_q[19:14];
          eta_q   <= rd_q[13:10];
          first_q <= rd_q[9:0];
          last_q  <= rd_q[9:0];
          rem_q[seed_q[IW-1:0]] <= 1'b0;
          j_q     <= seed_q + 1'b1;
          grew_q  <= 1'b0;
        end
        shc_pkg::StScan: begin
          if (j_end || (j_rem && (g_ch != ch_q || g_eta != eta_q))) begin
            j_q    <= seed_q + 1'b1;
            grew_q <= 1'b0;
          end else begin
            j_q <= j_q + 1'b1;
            if (j_rem) begin
              if (absorb_lo) begin
                first_q <= g_strip;
                rem_q[j_q[IW-1:0]] <= 1'b0;
                grew_q <= 1'b1;
              end else if (absorb_hi) begin
                last_q <= g_strip;
                rem_q[j_q[IW-1:0]] <= 1'b0;
                grew_q <= 1'b1;
              end
            end
          end
        end
        shc_pkg::StEmit: begin
          if (out_free) begin
            out_q.out_chamber   <= ch_q;
            out_q.out_eta       <= eta_q;
            out_q.first_strip   <= first_q;
            out_q.last_strip    <= last_q;
            out_q.cluster_size  <= 11'(last_q - first_q) + 11'd1;
            out_q.overflow      <= ov_q;
            out_q.final_cluster <= last_clus;
            // Event done: clear the event state for the next event.
            if (last_clus) begin
              rem_q   <= '0;
              count_q <= '0;
              drop_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/strip_hit_clusterer_top.sv @@
// Hits load one per cycle while the queue has room; an event's clusters follow its end-of-event hit.
// Each cluster then passes through seek steps over skipped hits, a seed step,
// scan passes over the later hits, rescanning while the cluster grows, and
// an emit step.
// The queue between loading and clustering holds 4 hits.
// Reset is asynchronous, active low, and clears all counters and flags.
module strip_hit_clusterer_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  shc_pkg::hit_in_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output shc_pkg::cluster_out_t out_data_o
);

  shc_pkg::hit_entry_t q_wdata, q_rdata;
  logic q_wr, q_full, q_empty, q_rd;

  shc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_wr), .q_full_i(q_full), .q_data_o(q_wdata)
  );

  shc_queue u_queue (
    .clk_i, .rst_ni, .wr_i(q_wr), .wr_data_i(q_wdata), .full_o(q_full),
    .empty_o(q_empty), .rd_i(q_rd), .rd_data_o(q_rdata)
  );

  shc_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_rdata), .q_rd_o(q_rd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef NO_ASSERTIONS
  a_q_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty) else $error("queue read while empty");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cluster_size ==
      11'(out_data_o.last_strip - out_data_o.first_strip) + 11'd1)
    else $error("cluster size mismatch");
`endif

endmodule

@@ tb/sv/tb_strip_hit_clusterer_top.sv @@
`timescale 1ns / 100ps

module tb_strip_hit_clusterer_top;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  shc_pkg::hit_in_t      in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  shc_pkg::cluster_out_t out_data_o;

  strip_hit_clusterer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor state: the hits of the event being collected.
  logic [19:0]  event_hits[shc_pkg::MaxHits];
  logic         hit_live[shc_pkg::MaxHits];
  int           event_count;
  logic         event_dropped;

  shc_pkg::hit_in_t      pending_hits[$];
  shc_pkg::cluster_out_t expected_clusters[$];

  int  mismatch_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_left;
  bit  hold_off_req;
  int  cycle_count;

  // Append one hit to the pending stimulus.
  task automatic add_hit(input shc_pkg::hit_in_t h);
    pending_hits = {pending_hits, h};
  endtask

  // Add one accepted hit and, at end of event, predict its clusters.
  task automatic predict_clusters(input shc_pkg::hit_in_t hit);
    logic [5:0]   seed_ch;
    logic [3:0]   seed_eta;
    logic [9:0]   lo_strip;
    logic [9:0]   hi_strip;
    logic [9:0]   s;
    bit           grew;
    int           seed;
    int           nfound;
    shc_pkg::cluster_out_t c;
    if (event_count < shc_pkg::MaxHits) begin
      event_hits[event_count] = {hit.chamber_id, hit.eta_sector, hit.strip_num};
      hit_live[event_count] = 1'b1;
      event_count++;
    end else begin
      event_dropped = 1'b1;
    end
    if (!hit.end_of_event) return;
    nfound = 0;
    for (seed = 0; seed < event_count; seed++) begin
      if (!hit_live[seed]) continue;
      seed_ch = event_hits[seed][19:14];
      seed_eta = event_hits[seed][13:10];
      lo_strip = event_hits[seed][9:0];
      hi_strip = lo_strip;
      hit_live[seed] = 1'b0;
      grew = 1'b1;
      while (grew) begin
        grew = 1'b0;
        for (int j = seed + 1; j < event_count; j++) begin
          if (!hit_live[j]) continue;
          if (event_hits[j][19:14] != seed_ch || event_hits[j][13:10] != seed_eta) break;
          s = event_hits[j][9:0];
          // Strip edges: no wraparound below 0 or above 1023.
          if (lo_strip != 0 && s == lo_strip - 10'd1) begin
            lo_strip = s;
            hit_live[j] = 1'b0;
            grew = 1'b1;
          end else if (hi_strip != 10'd1023 && s == hi_strip + 10'd1) begin
            hi_strip = s;
            hit_live[j] = 1'b0;
            grew = 1'b1;
          end
        end
      end
      c.out_chamber = seed_ch;
      c.out_eta = seed_eta;
      c.first_strip = lo_strip;
      c.last_strip = hi_strip;
      c.cluster_size = 11'(hi_strip) - 11'(lo_strip) + 11'd1;
      c.overflow = event_dropped;
      c.final_cluster = 1'b0;
      expected_clusters = {expected_clusters, c};
      nfound++;
    end
    if (nfound > 0) expected_clusters[$].final_cluster = 1'b1;
    for (int k = 0; k < shc_pkg::MaxHits; k++) hit_live[k] = 1'b0;
    event_count = 0;
    event_dropped = 1'b0;
  endtask

  function automatic shc_pkg::hit_in_t make_hit(int ch, int eta, int strip, bit eoe);
    shc_pkg::hit_in_t h;
    h.chamber_id = 6'(ch);
    h.eta_sector = 4'(eta);
    h.strip_num = 10'(strip);
    h.end_of_event = eoe;
    return h;
  endfunction

  // Queue one random event; mostly runs of neighbors in one chamber and eta.
  task automatic queue_random_event(input int nhits);
    int ch;
    int eta;
    int base;
    for (int i = 0; i < nhits; i++) begin
      if (i == 0 || $urandom_range(0, 5) == 0) begin
        ch = $urandom_range(0, 63);
        eta = $urandom_range(0, 15);
        base = $urandom_range(0, 1023);
      end
      if ($urandom_range(0, 9) == 0) begin
        add_hit(make_hit(ch, eta, $urandom_range(0, 1023), i == nhits - 1));
      end else begin
        add_hit(make_hit(ch, eta,
          (base + $urandom_range(0, 8) - 4) & 10'h3ff, i == nhits - 1));
      end
    end
  endtask

  // Driver: offers the next pending hit, holding it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_clusters(in_data_i);
        void'(pending_hits.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_hits.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct ||
            hold_off_left > 0)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_hits[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, including a long hold-off requested by the stimulus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_off_left <= 0;
    end else if (hold_off_req && hold_off_left == 0) begin
      hold_off_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall_i <= (hold_off_left > 1);
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: compares each accepted cluster with the oldest prediction.
  always @(posedge clk_i) begin
    shc_pkg::cluster_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_clusters.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected cluster transaction: %p", out_data_o);
      end else begin
        want = expected_clusters.pop_front();
        if (want !== out_data_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Cluster mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    event_count = 0;
    event_dropped = 1'b0;
    hold_off_req = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 63;
    for (int k = 0; k < shc_pkg::MaxHits; k++) hit_live[k] = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed events: field extremes, strip edges, repeats, breaks, overflow.
    add_hit(make_hit(63, 15, 1023, 1'b1));
    add_hit(make_hit(0, 0, 0, 1'b1));
    add_hit(make_hit(5, 3, 0, 1'b0));
    add_hit(make_hit(5, 3, 1023, 1'b0));
    add_hit(make_hit(5, 3, 1, 1'b0));
    add_hit(make_hit(5, 3, 1022, 1'b1));
    add_hit(make_hit(9, 7, 100, 1'b0));
    add_hit(make_hit(9, 7, 100, 1'b0));
    add_hit(make_hit(9, 7, 102, 1'b0));
    add_hit(make_hit(9, 7, 101, 1'b0));
    add_hit(make_hit(9, 8, 99, 1'b0));
    add_hit(make_hit(9, 7, 99, 1'b1));
    add_hit(make_hit(42, 10, 682, 1'b1));
    // Full store plus dropped hits, the last of them closing the event.
    for (int i = 0; i < shc_pkg::MaxHits + 3; i++)
      add_hit(make_hit(21, 5, 341 + 2 * (i % 40), i == shc_pkg::MaxHits + 2));

    // Random events while the receiver holds off once for a long stretch.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 63;
        recv_idle_pct = 33;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 50; ) begin
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        queue_random_event(len);
        n += len;
      end
      if (phase == 0) begin
        @(posedge clk_i);
        hold_off_req <= 1'b1;
        @(posedge clk_i);
        hold_off_req <= 1'b0;
      end
      while (pending_hits.size() > 0 || in_valid_i) @(posedge clk_i);
    end

    while (expected_clusters.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_clusters.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
